/* rtl/tksel_pkg.sv */
// ----------------------------------------------------------------------------
// tksel_pkg
// shared sizes, codes and state type of the top-k score select unit
// ----------------------------------------------------------------------------
`default_nettype none

package tksel_pkg;

    localparam int MAX_CLASSES = 1024;
    localparam int MAX_K       = 16;

    localparam int IDX_W   = $clog2(MAX_CLASSES);      // class index / store address
    localparam int CNT_W   = $clog2(MAX_CLASSES + 1);  // load count, holds MAX_CLASSES
    localparam int K_W     = $clog2(MAX_K + 1);        // rank and k, holds MAX_K
    localparam int SCORE_W = 16;
    localparam int ENTRY_W = SCORE_W + 1;              // {picked mark, score}

    localparam int IN_TDATA_W  = 16;
    localparam int OUT_TDATA_W = 32;
    localparam int APB_ADDR_W  = 3;
    localparam int APB_DATA_W  = 32;
    localparam int TOP_COUNT_W = 5;

    localparam logic [TOP_COUNT_W-1:0] TOP_COUNT_RESET = TOP_COUNT_W'(5);
    localparam logic signed [SCORE_W-1:0] NEG_ONE_Q14  = 16'sh C000;

    // register index decoded from paddr[2]
    localparam logic REG_TOP_COUNT = 1'b0;

    typedef enum logic [1:0] {
        ST_LOAD,
        ST_SCAN,
        ST_DRAIN,
        ST_EMIT
    } state_t;

endpackage

`default_nettype wire

/* rtl/tksel_ram.sv */
// ----------------------------------------------------------------------------
// tksel_ram
// generic single-port ram with registered read data
// ----------------------------------------------------------------------------
`default_nettype none

module tksel_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 1024
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] addr,
    input  wire logic [WIDTH-1:0]         wdata,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[addr] <= wdata;
        end
        rdata <= mem_reg[addr];
    end

endmodule

`default_nettype wire

/* rtl/top_k_score_select_unit.sv */
// ----------------------------------------------------------------------------
// top_k_score_select_unit
// loads one set of class scores, then reports the best top_count (at most MAX_K, at most the set size) of them
// ----------------------------------------------------------------------------
// channel  | dir | handshake         | payload
// ---------+-----+-------------------+---------------------------------------
// s_*      | in  | s_tvalid/s_tready | s_tdata = class_score, s_tlast = set_end
// m_*      | out | m_tvalid/m_tready | m_tdata = class_index, picked_score
//          |     |                   | m_tlast = run_end
// apb      | in  | psel/penable      | reg 0 (addr 0): top_count
//
// - a score beat is taken whenever s_tvalid is high while loading; s_tready
//   stays high until the beat that ends the set, or past it when k is zero
// - after the set end, each of the k results needs one pass over the n stored
//   scores through the single ram read port, then waits in the output register
//   until m_tready takes it
// - picked marks live in the ram next to each score and are written back as
//   clear on every load, so no clearing pass is needed after reset or per set
// - a stall on m_tready holds the output register and the sequencer; rst_n clears control
// ----------------------------------------------------------------------------
`default_nettype none

module top_k_score_select_unit (
    input  wire logic                                  clk,
    input  wire logic                                  rst_n,
    // score beats
    input  wire logic                                  s_tvalid,
    output logic                                       s_tready,
    input  wire logic [tksel_pkg::IN_TDATA_W-1:0]      s_tdata,   // [15:0] class_score
    input  wire logic                                  s_tlast,   // set_end
    // result beats
    output logic                                       m_tvalid,
    input  wire logic                                  m_tready,
    output logic      [tksel_pkg::OUT_TDATA_W-1:0]     m_tdata,   // [9:0] class_index,
                                                                  // [25:10] picked_score
    output logic                                       m_tlast,   // run_end
    // configuration
    input  wire logic                                  psel,
    input  wire logic                                  penable,
    input  wire logic                                  pwrite,
    input  wire logic [tksel_pkg::APB_ADDR_W-1:0]      paddr,
    input  wire logic [tksel_pkg::APB_DATA_W-1:0]      pwdata,
    output logic      [tksel_pkg::APB_DATA_W-1:0]      prdata,
    output logic                                       pready
);

    localparam int IDX_W   = tksel_pkg::IDX_W;
    localparam int CNT_W   = tksel_pkg::CNT_W;
    localparam int K_W     = tksel_pkg::K_W;
    localparam int SCORE_W = tksel_pkg::SCORE_W;
    localparam int ENTRY_W = tksel_pkg::ENTRY_W;

    tksel_pkg::state_t state_reg, state_next;

    logic [tksel_pkg::TOP_COUNT_W-1:0] top_count_reg;
    logic [CNT_W-1:0]   loaded_count_reg, loaded_count_next;
    logic [K_W-1:0]     rank_reg, rank_next;
    logic [K_W-1:0]     k_reg, k_next;
    logic [IDX_W-1:0]   scan_addr_reg, scan_addr_next;
    logic [IDX_W-1:0]   cmp_idx_reg, cmp_idx_next;
    logic               cmp_valid_reg, cmp_valid_next;
    logic signed [SCORE_W-1:0] best_val_reg, best_val_next;
    logic [IDX_W-1:0]   best_idx_reg, best_idx_next;
    logic               best_found_reg, best_found_next;
    logic signed [SCORE_W-1:0] out_score_reg, out_score_next;
    logic [IDX_W-1:0]   out_idx_reg, out_idx_next;
    logic               out_last_reg, out_last_next;

    // ram port
    logic               ram_we;
    logic [IDX_W-1:0]   ram_addr;
    logic [ENTRY_W-1:0] ram_wdata;
    logic [ENTRY_W-1:0] ram_rdata;

    // handshakes
    logic s_fire;
    logic m_fire;
    logic cfg_write;

    // load bookkeeping
    logic                  store_ok;
    logic [CNT_W-1:0]      n_after;
    logic [K_W-1:0]        top_sat;
    logic [K_W-1:0]        k_calc;
    logic                  scan_last;

    // shared compare unit
    logic signed [SCORE_W-1:0] cand_score;
    logic                      cand_mark;
    logic                      cand_better;
    logic signed [SCORE_W-1:0] upd_val;
    logic [IDX_W-1:0]          upd_idx;
    logic                      upd_found;

    assign s_tready = (state_reg == tksel_pkg::ST_LOAD);
    assign m_tvalid = (state_reg == tksel_pkg::ST_EMIT);
    assign s_fire   = s_tvalid && s_tready;
    assign m_fire   = m_tvalid && m_tready;
    assign m_tdata  = {{(tksel_pkg::OUT_TDATA_W - SCORE_W - IDX_W){1'b0}},
                       out_score_reg, out_idx_reg};
    assign m_tlast  = out_last_reg;

    // ------------------------------------------------------------------
    // configuration port
    // ------------------------------------------------------------------
    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite && pready;
    assign prdata    = (paddr[2] == tksel_pkg::REG_TOP_COUNT)
                       ? {{(tksel_pkg::APB_DATA_W - tksel_pkg::TOP_COUNT_W){1'b0}},
                          top_count_reg}
                       : '0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            top_count_reg <= tksel_pkg::TOP_COUNT_RESET;
        end
        else if (cfg_write && (paddr[2] == tksel_pkg::REG_TOP_COUNT))
        begin
            top_count_reg <= pwdata[tksel_pkg::TOP_COUNT_W-1:0];
        end
    end

    // ------------------------------------------------------------------
    // set length and k
    // ------------------------------------------------------------------
    assign store_ok = (loaded_count_reg < CNT_W'(tksel_pkg::MAX_CLASSES));
    assign n_after  = store_ok ? (loaded_count_reg + CNT_W'(1)) : loaded_count_reg;
    // top_count saturates at MAX_K, then k is clamped to the stored count
    assign top_sat  = ({{(K_W > tksel_pkg::TOP_COUNT_W ? K_W - tksel_pkg::TOP_COUNT_W : 0)
                         {1'b0}}, top_count_reg} > K_W'(tksel_pkg::MAX_K))
                      ? K_W'(tksel_pkg::MAX_K)
                      : K_W'(top_count_reg);
    assign k_calc   = (n_after < CNT_W'(top_sat)) ? n_after[K_W-1:0] : top_sat;

    assign scan_last = ({1'b0, scan_addr_reg} == (loaded_count_reg - CNT_W'(1)));

    // ------------------------------------------------------------------
    // compare unit: one stored entry per cycle against the running best
    // ------------------------------------------------------------------
    assign cand_score  = signed'(ram_rdata[SCORE_W-1:0]);
    assign cand_mark   = ram_rdata[SCORE_W];
    assign cand_better = cmp_valid_reg && !cand_mark && (cand_score > best_val_reg);
    assign upd_val     = cand_better ? cand_score  : best_val_reg;
    assign upd_idx     = cand_better ? cmp_idx_reg : best_idx_reg;
    assign upd_found   = cand_better || best_found_reg;

    // ------------------------------------------------------------------
    // sequencer: next state
    // ------------------------------------------------------------------
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            tksel_pkg::ST_LOAD:
            begin
                if (s_fire && s_tlast && (k_calc != '0))
                begin
                    state_next = tksel_pkg::ST_SCAN;
                end
            end
            tksel_pkg::ST_SCAN:
            begin
                if (scan_last)
                begin
                    state_next = tksel_pkg::ST_DRAIN;
                end
            end
            tksel_pkg::ST_DRAIN:
            begin
                state_next = tksel_pkg::ST_EMIT;
            end
            tksel_pkg::ST_EMIT:
            begin
                if (m_fire)
                begin
                    state_next = out_last_reg ? tksel_pkg::ST_LOAD : tksel_pkg::ST_SCAN;
                end
            end
            default:
            begin
                state_next = tksel_pkg::ST_LOAD;
            end
        endcase
    end

    // ------------------------------------------------------------------
    // sequencer: datapath and ram control
    // ------------------------------------------------------------------
    always_comb
    begin
        loaded_count_next = loaded_count_reg;
        rank_next         = rank_reg;
        k_next            = k_reg;
        scan_addr_next    = scan_addr_reg;
        cmp_idx_next      = cmp_idx_reg;
        cmp_valid_next    = 1'b0;
        best_val_next     = best_val_reg;
        best_idx_next     = best_idx_reg;
        best_found_next   = best_found_reg;
        out_score_next    = out_score_reg;
        out_idx_next      = out_idx_reg;
        out_last_next     = out_last_reg;
        ram_we            = 1'b0;
        ram_addr          = scan_addr_reg;
        ram_wdata         = '0;

        unique case (state_reg)
            tksel_pkg::ST_LOAD:
            begin
                if (s_fire)
                begin
                    if (store_ok)
                    begin
                        // new entry always goes in unpicked
                        ram_we    = 1'b1;
                        ram_addr  = loaded_count_reg[IDX_W-1:0];
                        ram_wdata = {1'b0, s_tdata[SCORE_W-1:0]};
                    end
                    loaded_count_next = n_after;
                    if (s_tlast)
                    begin
                        k_next          = k_calc;
                        rank_next       = '0;
                        scan_addr_next  = '0;
                        best_val_next   = tksel_pkg::NEG_ONE_Q14;
                        best_idx_next   = '0;
                        best_found_next = 1'b0;
                        if (k_calc == '0)
                        begin
                            loaded_count_next = '0;
                        end
                    end
                end
            end
            tksel_pkg::ST_SCAN:
            begin
                // read one entry, compare the one read last cycle
                cmp_valid_next  = 1'b1;
                cmp_idx_next    = scan_addr_reg;
                scan_addr_next  = scan_addr_reg + IDX_W'(1);
                best_val_next   = upd_val;
                best_idx_next   = upd_idx;
                best_found_next = upd_found;
            end
            tksel_pkg::ST_DRAIN:
            begin
                // last compare, then mark the winner
                out_score_next = upd_val;
                out_idx_next   = upd_idx;
                out_last_next  = ((rank_reg + K_W'(1)) == k_reg);
                if (upd_found)
                begin
                    ram_we    = 1'b1;
                    ram_addr  = upd_idx;
                    ram_wdata = {1'b1, upd_val};
                end
            end
            tksel_pkg::ST_EMIT:
            begin
                if (m_fire)
                begin
                    if (out_last_reg)
                    begin
                        loaded_count_next = '0;
                        rank_next         = '0;
                    end
                    else
                    begin
                        rank_next       = rank_reg + K_W'(1);
                        scan_addr_next  = '0;
                        best_val_next   = tksel_pkg::NEG_ONE_Q14;
                        best_idx_next   = '0;
                        best_found_next = 1'b0;
                    end
                end
            end
            default:
            begin
                ram_we = 1'b0;
            end
        endcase
    end

    // control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= tksel_pkg::ST_LOAD;
            loaded_count_reg <= '0;
            rank_reg         <= '0;
            k_reg            <= '0;
            scan_addr_reg    <= '0;
            cmp_valid_reg    <= 1'b0;
            best_found_reg   <= 1'b0;
            out_last_reg     <= 1'b0;
        end
        else
        begin
            state_reg        <= state_next;
            loaded_count_reg <= loaded_count_next;
            rank_reg         <= rank_next;
            k_reg            <= k_next;
            scan_addr_reg    <= scan_addr_next;
            cmp_valid_reg    <= cmp_valid_next;
            best_found_reg   <= best_found_next;
            out_last_reg     <= out_last_next;
        end
    end

    // payload
    always_ff @(posedge clk)
    begin
        cmp_idx_reg   <= cmp_idx_next;
        best_val_reg  <= best_val_next;
        best_idx_reg  <= best_idx_next;
        out_score_reg <= out_score_next;
        out_idx_reg   <= out_idx_next;
    end

    // score store with picked mark in the top bit
    tksel_ram #(
        .WIDTH (ENTRY_W),
        .DEPTH (tksel_pkg::MAX_CLASSES)
    ) u_store (
        .clk   (clk),
        .we    (ram_we),
        .addr  (ram_addr),
        .wdata (ram_wdata),
        .rdata (ram_rdata)
    );

endmodule

`default_nettype wire

/* rtl/tksel_checker.sv */
// ----------------------------------------------------------------------------
// tksel_checker
// port-level checks of the top-k score select unit, bound to the top level
// ----------------------------------------------------------------------------
`default_nettype none

module tksel_checker (
    input wire logic                              clk,
    input wire logic                              rst_n,
    input wire logic                              s_tvalid,
    input wire logic                              s_tready,
    input wire logic                              s_tlast,
    input wire logic                              m_tvalid,
    input wire logic                              m_tready,
    input wire logic [tksel_pkg::OUT_TDATA_W-1:0] m_tdata,
    input wire logic                              m_tlast
);

    // a held result beat keeps its payload
    assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tlast))
    else $error("result beat changed while stalled");

    // loading and reporting never overlap
    assert property (@(posedge clk) disable iff (!rst_n)
        !(s_tready && m_tvalid))
    else $error("score input open while a result is pending");

    // a score beat that does not end the set keeps the input open
    assert property (@(posedge clk) disable iff (!rst_n)
        s_tvalid && s_tready && !s_tlast |=> s_tready)
    else $error("input closed in the middle of a set");

    // the last result of a set reopens the input, any other does not
    assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tready |=> (s_tready == $past(m_tlast)))
    else $error("input state wrong after a result beat");

    // the empty-slot score only comes with class index zero
    assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && (m_tdata[25:10] == tksel_pkg::NEG_ONE_Q14) |-> (m_tdata[9:0] == '0))
    else $error("empty slot with nonzero class index");

endmodule

bind top_k_score_select_unit tksel_checker u_tksel_checker (
    .clk      (clk),
    .rst_n    (rst_n),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tlast  (s_tlast),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast)
);

`default_nettype wire

/* dv/tb_top.sv */
// ----------------------------------------------------------------------------
// tb_top
// self-checking bench for the top-k score select unit: streams score sets
// under several top_count settings, predicts the ranked picks of each set
// and compares every result beat field by field
// ----------------------------------------------------------------------------

module tb_top;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int MAX_CLASSES = tksel_pkg::MAX_CLASSES;
    localparam int MAX_K       = tksel_pkg::MAX_K;
    localparam int IDX_W       = tksel_pkg::IDX_W;
    localparam int SCORE_W     = tksel_pkg::SCORE_W;
    localparam int IN_TDATA_W  = tksel_pkg::IN_TDATA_W;
    localparam int OUT_TDATA_W = tksel_pkg::OUT_TDATA_W;
    localparam int APB_ADDR_W  = tksel_pkg::APB_ADDR_W;
    localparam int APB_DATA_W  = tksel_pkg::APB_DATA_W;
    localparam int TOP_COUNT_W = tksel_pkg::TOP_COUNT_W;

    localparam logic [TOP_COUNT_W-1:0]    TOP_COUNT_RESET = tksel_pkg::TOP_COUNT_RESET;
    localparam logic signed [SCORE_W-1:0] NEG_ONE_Q14     = tksel_pkg::NEG_ONE_Q14;
    localparam logic                      REG_TOP_COUNT   = tksel_pkg::REG_TOP_COUNT;

    localparam int CLK_HALF     = 5;
    localparam int RESET_CYCLES = 8;
    localparam int CYCLE_LIMIT  = 1_000_000;
    localparam int BURST_MAX    = 13;
    localparam int PHASE_ITEMS  = 50;

    // top_count lives at byte address 4 * register index
    localparam logic [APB_ADDR_W-1:0] TOP_COUNT_ADDR = {REG_TOP_COUNT, 2'b00};

    // one score beat as the sender holds it
    typedef struct packed {
        logic [SCORE_W-1:0] score;
        logic               last;
    } score_beat_t;

    // one ranked pick as the unit should report it
    typedef struct packed {
        logic [IDX_W-1:0]   idx;
        logic [SCORE_W-1:0] score;
        logic               last;
    } pick_t;

    // flavors of random score sets
    typedef enum int unsigned {
        MIX_UNIFORM,
        MIX_EDGES,
        MIX_TIES,
        MIX_FLOOR
    } score_mix_t;

    // ------------------------------------------------------------------------
    // clock, reset and the unit's ports
    // ------------------------------------------------------------------------
    logic                   clk      = 1'b0;
    logic                   rst_n    = 1'b0;
    logic                   s_tvalid = 1'b0;
    logic                   s_tready;
    logic [IN_TDATA_W-1:0]  s_tdata  = '0;    // [15:0] class_score
    logic                   s_tlast  = 1'b0;  // set_end
    logic                   m_tvalid;
    logic                   m_tready = 1'b0;
    logic [OUT_TDATA_W-1:0] m_tdata;          // [9:0] class_index, [25:10] picked_score
    logic                   m_tlast;          // run_end
    logic                   psel     = 1'b0;
    logic                   penable  = 1'b0;
    logic                   pwrite   = 1'b0;
    logic [APB_ADDR_W-1:0]  paddr    = '0;
    logic [APB_DATA_W-1:0]  pwdata   = '0;
    logic [APB_DATA_W-1:0]  prdata;
    logic                   pready;

    always #CLK_HALF clk = ~clk;

    top_k_score_select_unit uut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tlast  (s_tlast),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready)
    );

    // ------------------------------------------------------------------------
    // bench state
    // ------------------------------------------------------------------------
    score_beat_t pending_scores [$];   // beats waiting for the sender
    pick_t       expected_picks [$];   // picks predicted but not yet seen

    // shadow of the unit: stored scores, picked marks, load count, register
    logic signed [SCORE_W-1:0]  class_scores [MAX_CLASSES];
    bit                         taken_mark   [MAX_CLASSES];
    int unsigned                loaded_scores = 0;
    logic [TOP_COUNT_W-1:0]     top_count_cfg = TOP_COUNT_RESET;

    int unsigned scores_queued   = 0;
    int unsigned scores_accepted = 0;
    int unsigned picks_seen      = 0;
    int unsigned sets_closed     = 0;
    int unsigned settings_used   = 0;
    int unsigned mismatches      = 0;
    int unsigned cycle_count     = 0;
    int unsigned tail_cycles     = 0;

    // sender / receiver pacing
    bit          beat_taken   = 1'b0;
    bit          src_idle_on  = 1'b0;
    bit          sink_idle_on = 1'b0;
    int unsigned src_gap      = 0;
    int unsigned sink_gap     = 0;

    // ------------------------------------------------------------------------
    // mismatch reporting: one line each, and counted
    // ------------------------------------------------------------------------
    task automatic report_mismatch(string what, int want, int got);
        $display("[%0t] mismatch on %s: expected %0d, got %0d", $realtime, what, want, got);
        mismatches++;
    endtask

    // ------------------------------------------------------------------------
    // prediction: store the score, and on the set end rank the set
    // ------------------------------------------------------------------------
    function automatic void take_score(logic [SCORE_W-1:0] score, logic set_end);
        int unsigned k;
        int unsigned best_idx;
        int          best_val;
        bit          found;
        pick_t       pick;

        // scores past the store depth are dropped, the set end still counts
        if (loaded_scores < MAX_CLASSES)
        begin
            class_scores[loaded_scores] = score;
            loaded_scores++;
        end
        if (!set_end)
            return;

        // k saturates at MAX_K and never exceeds the stored count
        k = top_count_cfg;
        if (k > MAX_K)
            k = MAX_K;
        if (k > loaded_scores)
            k = loaded_scores;

        for (int r = 0; r < k; r++)
        begin
            // only scores strictly above -1.0 qualify, strict > keeps the
            // lowest index on ties
            best_idx = 0;
            best_val = NEG_ONE_Q14;
            found    = 1'b0;
            for (int c = 0; c < loaded_scores; c++)
            begin
                if (!taken_mark[c] && class_scores[c] > best_val)
                begin
                    best_val = class_scores[c];
                    best_idx = c;
                    found    = 1'b1;
                end
            end
            // an empty slot reports index 0 at -1.0 and marks nothing
            if (found)
                taken_mark[best_idx] = 1'b1;
            pick.idx   = IDX_W'(best_idx);
            pick.score = SCORE_W'(best_val);
            pick.last  = (r + 1 == k);
            expected_picks.push_back(pick);
        end

        for (int c = 0; c < MAX_CLASSES; c++)
            taken_mark[c] = 1'b0;
        loaded_scores = 0;
        sets_closed++;
    endfunction

    // ------------------------------------------------------------------------
    // monitor: accepted score beats feed the predictor, result beats are
    // checked against the oldest prediction; also the run watchdog
    // ------------------------------------------------------------------------
    always @(posedge clk)
    begin
        pick_t want;

        if (rst_n)
        begin
            cycle_count++;
            if (s_tvalid && s_tready)
            begin
                take_score(s_tdata[SCORE_W-1:0], s_tlast);
                scores_accepted++;
                beat_taken = 1'b1;
            end
            if (m_tvalid && m_tready)
            begin
                picks_seen++;
                if (expected_picks.size() == 0)
                    report_mismatch("unexpected result beat, class_index", -1,
                                    int'(m_tdata[IDX_W-1:0]));
                else
                begin
                    want = expected_picks.pop_front();
                    if (m_tdata[IDX_W-1:0] !== want.idx)
                        report_mismatch("class_index", int'(want.idx),
                                        int'(m_tdata[IDX_W-1:0]));
                    if (m_tdata[IDX_W+SCORE_W-1:IDX_W] !== want.score)
                        report_mismatch("picked_score", int'($signed(want.score)),
                                        int'($signed(m_tdata[IDX_W+SCORE_W-1:IDX_W])));
                    if (m_tlast !== want.last)
                        report_mismatch("run_end", int'(want.last), int'(m_tlast));
                end
            end
            if (cycle_count >= CYCLE_LIMIT)
            begin
                $display("watchdog expired after %0d cycles, %0d picks outstanding",
                         cycle_count, expected_picks.size());
                $display("FAIL top_k_score_select_unit");
                $finish;
            end
        end
    end

    // ------------------------------------------------------------------------
    // sender: pops pending beats, holds each until taken, random idle bursts
    // between beats
    // ------------------------------------------------------------------------
    always @(negedge clk)
    begin
        score_beat_t beat;

        if (rst_n && (!s_tvalid || beat_taken))
        begin
            beat_taken = 1'b0;
            if (src_gap > 0)
            begin
                src_gap--;
                s_tvalid <= 1'b0;
            end
            else if (pending_scores.size() != 0)
            begin
                beat = pending_scores.pop_front();
                s_tdata  <= beat.score;
                s_tlast  <= beat.last;
                s_tvalid <= 1'b1;
                // idle burst ahead of the next beat
                if (src_idle_on && $urandom_range(7) == 0)
                    src_gap = $urandom_range(BURST_MAX, 1);
            end
            else
                s_tvalid <= 1'b0;
        end
    end

    // receiver: ready by default, dropped for random bursts when idling is on
    always @(negedge clk)
    begin
        if (rst_n)
        begin
            if (sink_gap > 0)
            begin
                sink_gap--;
                m_tready <= 1'b0;
            end
            else if (sink_idle_on && $urandom_range(9) == 0)
            begin
                sink_gap = $urandom_range(BURST_MAX - 1, 0);
                m_tready <= 1'b0;
            end
            else
                m_tready <= 1'b1;
        end
    end

    // ------------------------------------------------------------------------
    // configuration access
    // ------------------------------------------------------------------------
    task automatic write_top_count(logic [APB_DATA_W-1:0] data);
        @(negedge clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= TOP_COUNT_ADDR;
        pwdata  <= data;
        @(negedge clk);
        penable <= 1'b1;
        do @(posedge clk); while (!pready);
        top_count_cfg = data[TOP_COUNT_W-1:0];
        @(negedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    task automatic check_top_count(logic [TOP_COUNT_W-1:0] want);
        logic [APB_DATA_W-1:0] got;

        @(negedge clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        paddr   <= TOP_COUNT_ADDR;
        @(negedge clk);
        penable <= 1'b1;
        do @(posedge clk); while (!pready);
        got = prdata;
        @(negedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        if (got[TOP_COUNT_W-1:0] !== want)
            report_mismatch("top_count readback", int'(want), int'(got[TOP_COUNT_W-1:0]));
    endtask

    // ------------------------------------------------------------------------
    // stimulus helpers
    // ------------------------------------------------------------------------
    function automatic void queue_beat(logic [SCORE_W-1:0] score, logic last);
        score_beat_t beat;

        beat.score = score;
        beat.last  = last;
        pending_scores.push_back(beat);
        scores_queued++;
    endfunction

    // one whole set of n scores, set end on the last one
    task automatic queue_set(int unsigned n, score_mix_t mix);
        logic [SCORE_W-1:0] pool [4];
        logic [SCORE_W-1:0] score;

        @(posedge clk);
        foreach (pool[p])
            pool[p] = SCORE_W'($urandom);
        for (int i = 0; i < n; i++)
        begin
            case (mix)
                MIX_UNIFORM: score = SCORE_W'($urandom);
                MIX_EDGES:
                    case ($urandom_range(5))
                        0:       score = 16'h8000;
                        1:       score = 16'hBFFF;
                        2:       score = 16'hC000;
                        3:       score = 16'hC001;
                        4:       score = 16'h7FFF;
                        default: score = 16'h0000;
                    endcase
                MIX_TIES:    score = pool[$urandom_range(3)];
                // mostly at or below -1.0 so slots run out of candidates
                default:
                    if ($urandom_range(5) == 0)
                        score = SCORE_W'($urandom_range(16'h7FFF, 0));
                    else if ($urandom_range(7) == 0)
                        score = 16'h8000;
                    else
                        score = NEG_ONE_Q14 - SCORE_W'($urandom_range(300));
            endcase
            // past the store depth: scores that would win if not dropped
            if (i >= MAX_CLASSES)
                score = 16'h7FFF;
            queue_beat(score, i == n - 1);
        end
        if (n + 32 > tail_cycles)
            tail_cycles = n + 32;
    endtask

    // all queued beats taken and every predicted pick seen
    task automatic wait_drained();
        do @(negedge clk);
        while (scores_accepted != scores_queued || expected_picks.size() != 0);
    endtask

    // one setting of top_count followed by random sets; upper data bits are
    // random and must be ignored by the register
    task automatic run_phase(logic [TOP_COUNT_W-1:0] count, int unsigned budget,
                             bit idle_on, bit hold_midway, bit with_long_set);
        int unsigned sent;
        int unsigned n;

        wait_drained();
        // a top_count of zero leaves no result to mark the end of the work
        repeat (tail_cycles) @(negedge clk);
        tail_cycles = 0;
        write_top_count(($urandom & ~32'(2**TOP_COUNT_W - 1)) | APB_DATA_W'(count));
        check_top_count(count);
        settings_used++;

        @(posedge clk);
        src_idle_on  = idle_on;
        sink_idle_on = idle_on;
        if (with_long_set)
            queue_set(MAX_CLASSES + 6, MIX_UNIFORM);
        sent = 0;
        while (sent < budget)
        begin
            case ($urandom_range(9))
                0:       n = 1;
                1, 2:    n = $urandom_range(48, 25);
                default: n = $urandom_range(20, 2);
            endcase
            queue_set(n, score_mix_t'($urandom_range(3)));
            sent += n;
            // sender holds off until the unit has reported everything
            if (hold_midway && sent >= budget / 2)
            begin
                hold_midway = 1'b0;
                wait_drained();
            end
        end
    endtask

    // ------------------------------------------------------------------------
    // test sequence
    // ------------------------------------------------------------------------
    initial
    begin
        repeat (RESET_CYCLES) @(negedge clk);
        rst_n <= 1'b1;
        check_top_count(TOP_COUNT_RESET);

        // directed sets at the reset top_count
        @(posedge clk);
        // full-scale extremes, -1.0 excluded, ties on the top and on zero
        queue_beat(16'h7FFF, 1'b0);
        queue_beat(16'h8000, 1'b0);
        queue_beat(16'hC000, 1'b0);
        queue_beat(16'hC001, 1'b0);
        queue_beat(16'h0000, 1'b0);
        queue_beat(16'h0000, 1'b0);
        queue_beat(16'h7FFF, 1'b1);
        // one candidate, then empty slots
        queue_beat(16'hC000, 1'b0);
        queue_beat(16'h8000, 1'b0);
        queue_beat(16'h1234, 1'b1);
        // single score set, k clamps to one
        queue_beat(16'h7FFF, 1'b1);
        // candidates run out after four picks
        queue_beat(16'h4000, 1'b0);
        queue_beat(16'hBFFF, 1'b0);
        queue_beat(16'hFFFF, 1'b0);
        queue_beat(16'h0001, 1'b0);
        queue_beat(16'h4000, 1'b0);
        queue_beat(16'h8001, 1'b1);
        tail_cycles = 40;

        // random phases over the extremes and a few settings between
        run_phase(1,                                     PHASE_ITEMS, 1'b1, 1'b0, 1'b0);
        run_phase(16,                                    PHASE_ITEMS, 1'b1, 1'b1, 1'b0);
        run_phase(31,                                    PHASE_ITEMS, 1'b0, 1'b0, 1'b0);
        run_phase(0,                                     PHASE_ITEMS, 1'b1, 1'b0, 1'b0);
        run_phase(17,                                    PHASE_ITEMS, 1'b1, 1'b0, 1'b0);
        run_phase(TOP_COUNT_W'($urandom_range(MAX_K, 2)), PHASE_ITEMS, 1'b1, 1'b0, 1'b0);
        run_phase(TOP_COUNT_W'($urandom_range(31, 0)),    PHASE_ITEMS, 1'b1, 1'b0, 1'b0);
        // closing stretch with both sides always ready
        run_phase(TOP_COUNT_RESET,                       PHASE_ITEMS, 1'b0, 1'b0, 1'b0);

        wait_drained();
        repeat (tail_cycles) @(negedge clk);
        if (expected_picks.size() != 0)
            report_mismatch("picks never reported", 0, expected_picks.size());

        $display("ran %0d score sets (%0d score beats) under %0d top_count settings",
                 sets_closed, scores_accepted, settings_used + 1);
        $display("checked %0d result beats in %0d cycles, %0d mismatches",
                 picks_seen, cycle_count, mismatches);
        if (mismatches == 0)
            $display("PASS top_k_score_select_unit");
        else
            $display("FAIL top_k_score_select_unit");
        $finish;
    end

endmodule

/* sim.f */
rtl/tksel_pkg.sv
rtl/tksel_ram.sv
rtl/top_k_score_select_unit.sv
rtl/tksel_checker.sv
dv/tb_top.sv
